### design/u8d_pkg.sv
// shared types and codes for the utf-8 stream decoder
package u8d_pkg;

  // byte classes found by the front end
  localparam logic [2:0] KIND_ASCII = 3'd0;
  localparam logic [2:0] KIND_LEAD2 = 3'd1;
  localparam logic [2:0] KIND_LEAD3 = 3'd2;
  localparam logic [2:0] KIND_LEAD4 = 3'd3;
  localparam logic [2:0] KIND_CONT  = 3'd4;
  localparam logic [2:0] KIND_BAD   = 3'd5;

  // result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_LEAD  = 2'd1;
  localparam logic [1:0] STATUS_MISSING   = 2'd2;
  localparam logic [1:0] STATUS_TRUNCATED = 2'd3;

  // classification queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam int CP_W  = 21;
  localparam int LEN_W = 3;

  typedef struct packed {
    logic [2:0] kind;
    logic [6:0] bits;  // payload bits already stripped of the marker
    logic       last;
  } byte_info_t;

endpackage

### design/utf8_stream_decoder.sv
// top level of the utf-8 stream decoder
//
// input channel s_*: one raw byte per transaction, s_tlast marks the last
// byte of a buffer. output channel m_*: one result transaction per finished
// sequence, per fault, and per byte with s_tlast set; m_tlast copies the
// end mark of the byte that closed the result.
// a byte is classified as soon as it is accepted and goes into a 4-entry
// queue; the assembler behind it takes one byte per cycle from the queue
// and loads the result register, as long as that register is free or
// draining. throughput is one byte per cycle while m_tready stays high;
// a closing byte passes through a queue entry, then the result register.
// a fault (bad lead byte, missing continuation, truncated sequence) gives
// one result with zero code point and length and drops the partial
// sequence together with the offending byte.
// when m_tready is low while a result waits, the result register holds,
// the assembler stops and the queue fills; s_tready falls once all four
// entries are taken. rst (synchronous) empties the queue, clears the
// result valid flag and leaves the assembler idle.
module utf8_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,   // end_of_input
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [20:0] cp_value, [23:21] seq_length, [25:24] status
  output logic        m_tlast    // stream_end
);

  u8d_pkg::byte_info_t               in_info;
  u8d_pkg::byte_info_t               q_info;
  logic                              q_valid;
  logic                              q_ready;
  logic [u8d_pkg::CP_W-1:0]          res_cp;
  logic [u8d_pkg::LEN_W-1:0]         res_len;
  logic [1:0]                        res_status;

  // classify straight off the input bus
  u8d_front u_front (
    .in_byte      (s_tdata),
    .end_of_input (s_tlast),
    .info         (in_info)
  );

  // decouples input acceptance from result back-pressure
  u8d_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (s_tvalid),
    .wr_ready (s_tready),
    .wr_data  (in_info),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_info)
  );

  // sequence assembly and output register
  u8d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_data     (q_info),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_cp     (res_cp),
    .out_len    (res_len),
    .out_status (res_status),
    .out_last   (m_tlast)
  );

  // pack the result fields, upper bits padded with zeros
  assign m_tdata = {6'd0, res_status, res_len, res_cp};

endmodule

### design/u8d_front.sv
// front end: classifies a raw byte and strips its marker bits
module u8d_front (
  input  logic [7:0]          in_byte,
  input  logic                end_of_input,
  output u8d_pkg::byte_info_t info
);

  always_comb begin
    info.last = end_of_input;
    unique casez (in_byte)
      8'b0???????: begin
        info.kind = u8d_pkg::KIND_ASCII;
        info.bits = in_byte[6:0];
      end
      8'b10??????: begin
        info.kind = u8d_pkg::KIND_CONT;
        info.bits = {1'b0, in_byte[5:0]};
      end
      8'b110?????: begin
        info.kind = u8d_pkg::KIND_LEAD2;
        info.bits = {2'b0, in_byte[4:0]};
      end
      8'b1110????: begin
        info.kind = u8d_pkg::KIND_LEAD3;
        info.bits = {3'b0, in_byte[3:0]};
      end
      8'b11110???: begin
        info.kind = u8d_pkg::KIND_LEAD4;
        info.bits = {4'b0, in_byte[2:0]};
      end
      default: begin
        info.kind = u8d_pkg::KIND_BAD;
        info.bits = 7'd0;
      end
    endcase
  end

endmodule

### design/u8d_queue.sv
// small fifo between the classifier and the sequence assembler
module u8d_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_valid,
  output logic                wr_ready,
  input  u8d_pkg::byte_info_t wr_data,
  output logic                rd_valid,
  input  logic                rd_ready,
  output u8d_pkg::byte_info_t rd_data
);

  u8d_pkg::byte_info_t entries [u8d_pkg::QUEUE_DEPTH];
  logic [u8d_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [u8d_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [u8d_pkg::QUEUE_CW-1:0] count;
  logic                          do_wr;
  logic                          do_rd;

  assign wr_ready = (count != u8d_pkg::QUEUE_CW'(u8d_pkg::QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = entries[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### design/u8d_back.sv
// back end: assembles sequences and holds the result register
module u8d_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  output logic                       q_ready,
  input  u8d_pkg::byte_info_t        q_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [u8d_pkg::CP_W-1:0]   out_cp,
  output logic [u8d_pkg::LEN_W-1:0]  out_len,
  output logic [1:0]                 out_status,
  output logic                       out_last
);

  logic [u8d_pkg::CP_W-1:0]  payload;
  logic [1:0]                pending;
  logic [u8d_pkg::LEN_W-1:0] total;

  logic [u8d_pkg::CP_W-1:0]  payload_next;
  logic [1:0]                pending_next;
  logic [u8d_pkg::LEN_W-1:0] total_next;
  logic                      emit;
  logic [u8d_pkg::CP_W-1:0]  emit_cp;
  logic [u8d_pkg::LEN_W-1:0] emit_len;
  logic [1:0]                emit_status;
  logic [u8d_pkg::CP_W-1:0]  shifted;
  logic [1:0]                pending_dec;
  logic                      take;

  // result register is free, or is being drained this cycle
  assign q_ready = !out_valid || out_ready;
  assign take    = q_valid && q_ready;

  assign shifted     = {payload[u8d_pkg::CP_W-7:0], q_data.bits[5:0]};
  assign pending_dec = pending - 1'b1;

  always_comb begin
    payload_next = payload;
    pending_next = pending;
    total_next   = total;
    emit         = 1'b0;
    emit_cp      = '0;
    emit_len     = '0;
    emit_status  = u8d_pkg::STATUS_OK;
    if (pending == 2'd0) begin
      unique case (q_data.kind)
        u8d_pkg::KIND_ASCII: begin
          emit     = 1'b1;
          emit_cp  = u8d_pkg::CP_W'(q_data.bits);
          emit_len = u8d_pkg::LEN_W'(1);
        end
        u8d_pkg::KIND_LEAD2, u8d_pkg::KIND_LEAD3, u8d_pkg::KIND_LEAD4: begin
          payload_next = u8d_pkg::CP_W'(q_data.bits);
          pending_next = q_data.kind[1:0];
          total_next   = u8d_pkg::LEN_W'(q_data.kind[1:0]) + 1'b1;
          if (q_data.last) begin
            emit         = 1'b1;
            emit_status  = u8d_pkg::STATUS_TRUNCATED;
            pending_next = 2'd0;
          end
        end
        default: begin
          emit        = 1'b1;
          emit_status = u8d_pkg::STATUS_BAD_LEAD;
        end
      endcase
    end else if (q_data.kind != u8d_pkg::KIND_CONT) begin
      emit         = 1'b1;
      emit_status  = u8d_pkg::STATUS_MISSING;
      pending_next = 2'd0;
    end else begin
      payload_next = shifted;
      pending_next = pending_dec;
      if (pending_dec == 2'd0) begin
        emit     = 1'b1;
        emit_cp  = shifted;
        emit_len = total;
      end else if (q_data.last) begin
        emit         = 1'b1;
        emit_status  = u8d_pkg::STATUS_TRUNCATED;
        pending_next = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        pending <= pending_next;
      end
      if (take) begin
        out_valid <= emit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      payload <= payload_next;
      total   <= total_next;
    end
    if (take && emit) begin
      out_cp     <= emit_cp;
      out_len    <= emit_len;
      out_status <= emit_status;
      out_last   <= q_data.last;
    end
  end

endmodule
